/* sv/uart_receive_ring_buffer_macros.svh */
// Assertion macros shared by the ring buffer checks.
`ifndef UART_RECEIVE_RING_BUFFER_MACROS_SVH
`define UART_RECEIVE_RING_BUFFER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define URRB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uart receive ring buffer check failed");

// Check a property on every clock edge, reset included.
`define URRB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("uart receive ring buffer check failed");

`endif

/* sv/urrb_pkg.sv */
package urrb_pkg;

  localparam logic       MODE_READ  = 1'b1;
  localparam logic [7:0] EOM_RESET  = 8'd13;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_STORE,
    OP_READ,
    OP_OVERRUN,
    OP_FRAMING
  } op_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       overrun_error;
    logic       framing_error;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       buffer_empty;
    logic       buffer_full;
    logic [7:0] overrun_errors;
    logic [7:0] framing_errors;
    logic [7:0] buffer_overruns;
    logic [7:0] message_count;
    logic       receiver_restart;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

endpackage

/* sv/uart_receive_ring_buffer.sv */
// Receive ring buffer for a serial port. Each word on rx_item is either a
// received byte (mode 0, with the receiver's overrun and framing flags) or a
// request to pop the head byte (mode 1). Every accepted word produces exactly
// one result, shown on result for a single cycle with result_valid high; the
// receiver cannot stall, so result must be captured in that cycle. The result
// passes through the front register, the command queue and the back end,
// whose byte store read is registered. Words may be accepted every cycle;
// the back end retires one per cycle, so the queue never holds more than one
// word and busy stays low.
// No clearing pass is run after reset: unwritten store entries are never read.
module uart_receive_ring_buffer
  import urrb_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       start,
  output logic       busy,
  input  in_t        rx_item,
  // result channel, one-cycle strobe
  output logic       result_valid,
  output out_t       result,
  // end-of-message byte register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic       push_valid;
  cmd_t       push_cmd;
  logic       push_ready;
  logic       cmd_valid;
  cmd_t       cmd;
  logic [7:0] eom_byte;

  // register writes only arrive while idle is a rule for the user, not enforced here, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eom_byte <= EOM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eom_byte <= cfg_data;
    end
  end

  // front: take the word and decode it into a command
  urrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .rx_item   (rx_item),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready)
  );

  // short queue decoupling decode from execution
  urrb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd)
  );

  // back: ring buffer state, counters and byte store
  urrb_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .eom_byte    (eom_byte),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

/* sv/urrb_ram.sv */
module urrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/urrb_front.sv */
module urrb_front
  import urrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  rx_item,
  output logic push_valid,
  output cmd_t push_cmd,
  input  logic push_ready
);

  logic front_valid;
  cmd_t front_cmd;
  cmd_t cls_cmd;
  logic accept;

  // overrun wins over framing; flags mean nothing on a read
  always_comb begin
    cls_cmd.data = rx_item.rx_byte;
    if (rx_item.mode == MODE_READ) begin
      cls_cmd.op = OP_READ;
    end else if (rx_item.overrun_error) begin
      cls_cmd.op = OP_OVERRUN;
    end else if (rx_item.framing_error) begin
      cls_cmd.op = OP_FRAMING;
    end else begin
      cls_cmd.op = OP_STORE;
    end
  end

  assign busy       = front_valid && !push_ready;
  assign accept     = start && !busy;
  assign push_valid = front_valid;
  assign push_cmd   = front_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push_ready) begin
      front_valid <= 1'b0;
    end
    if (accept) begin
      front_cmd <= cls_cmd;
    end
  end

endmodule

/* sv/urrb_queue.sv */
module urrb_queue
  import urrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  // back end drains one word per cycle whenever one is present
  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* sv/urrb_back.sv */
module urrb_back
  import urrb_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  input  logic [7:0] eom_byte,
  output logic       result_valid,
  output out_t       result
);

  localparam int IDX_W = $clog2(BUF_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [IDX_W-1:0] last_tail, last_tail_next;
  logic             full, full_next;
  logic             empty, empty_next;
  logic [7:0]       ovr_cnt, ovr_cnt_next;
  logic [7:0]       frm_cnt, frm_cnt_next;
  logic [7:0]       bo_cnt, bo_cnt_next;
  logic [7:0]       msg_cnt, msg_cnt_next;
  logic             res_valid, rd_sel, rd_sel_next, restart, restart_next;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_rdata;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  urrb_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.data),
    .re   (ram_re),
    .raddr(head),
    .rdata(ram_rdata)
  );

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    last_tail_next = last_tail;
    full_next      = full;
    empty_next     = empty;
    ovr_cnt_next   = ovr_cnt;
    frm_cnt_next   = frm_cnt;
    bo_cnt_next    = bo_cnt;
    msg_cnt_next   = msg_cnt;
    rd_sel_next    = 1'b0;
    restart_next   = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = tail;
    if (cmd_valid) begin
      case (cmd.op)
        OP_READ: begin
          if (!empty) begin
            ram_re      = 1'b1;
            rd_sel_next = 1'b1;
            head_next   = next_idx(head);
            empty_next  = (next_idx(head) == tail);
            full_next   = 1'b0;
          end
        end
        OP_OVERRUN: begin
          ovr_cnt_next = sat_inc(ovr_cnt);
          restart_next = 1'b1;
        end
        OP_FRAMING: begin
          frm_cnt_next = sat_inc(frm_cnt);
        end
        OP_STORE: begin
          ram_we = 1'b1;
          if (full) begin
            // full: replace the newest entry, indices hold
            ram_waddr   = last_tail;
            bo_cnt_next = sat_inc(bo_cnt);
          end else begin
            last_tail_next = tail;
            tail_next      = next_idx(tail);
            full_next      = (next_idx(tail) == head);
            empty_next     = 1'b0;
          end
          if (cmd.data == eom_byte) begin
            msg_cnt_next = sat_inc(msg_cnt);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      last_tail <= LAST_IDX;
      full      <= 1'b0;
      empty     <= 1'b1;
      ovr_cnt   <= '0;
      frm_cnt   <= '0;
      bo_cnt    <= '0;
      msg_cnt   <= '0;
      res_valid <= 1'b0;
      rd_sel    <= 1'b0;
      restart   <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      last_tail <= last_tail_next;
      full      <= full_next;
      empty     <= empty_next;
      ovr_cnt   <= ovr_cnt_next;
      frm_cnt   <= frm_cnt_next;
      bo_cnt    <= bo_cnt_next;
      msg_cnt   <= msg_cnt_next;
      res_valid <= cmd_valid;
      rd_sel    <= rd_sel_next;
      restart   <= restart_next;
    end
  end

  // state registers already hold the after-step values in the strobe cycle
  assign result_valid             = res_valid;
  assign result.read_data         = rd_sel ? ram_rdata : 8'd0;
  assign result.buffer_empty      = empty;
  assign result.buffer_full       = full;
  assign result.overrun_errors    = ovr_cnt;
  assign result.framing_errors    = frm_cnt;
  assign result.buffer_overruns   = bo_cnt;
  assign result.message_count     = msg_cnt;
  assign result.receiver_restart  = restart;

endmodule

/* sv/urrb_checker.sv */
`include "uart_receive_ring_buffer_macros.svh"

module urrb_checker
  import urrb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input out_t       result
);

  // buffer can never be both empty and full
  `URRB_ASSERT(a_not_empty_and_full, clk, rst,
    result_valid |-> !(result.buffer_empty && result.buffer_full))

  // a restart pulse only rides on a result and implies a counted overrun
  `URRB_ASSERT(a_restart_counted, clk, rst,
    result.receiver_restart |-> (result_valid && result.overrun_errors != 8'd0))

  // every accepted word yields its result after the front, queue and back end registers
  `URRB_ASSERT(a_result_latency, clk, rst,
    (start && !busy) |-> ##3 result_valid)

  // no result strobe right after a reset cycle
  `URRB_ASSERT_ALWAYS(a_quiet_after_reset, clk,
    rst |=> !result_valid)

endmodule

bind uart_receive_ring_buffer urrb_checker u_urrb_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the serial receive ring buffer.
// The driver presents words from rx_words.
// On every accepted word, the ring model predicts the one result and queues it
// on due_results. The monitor compares each strobed result with the oldest
// prediction, field by field.
module tb_top;
  import urrb_pkg::*;

  localparam int   DEPTH      = 128;
  localparam int   RING_IDX_W = $clog2(DEPTH);
  localparam logic MODE_RX    = 1'b0;   // received byte event
  localparam int   STALL_MAX  = 2000;   // cycles with no traffic before giving up
  localparam int   DRAIN_WAIT = 6;      // pipeline is three deep, leave margin

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic start   = 1'b0;
  logic busy;
  in_t  rx_item = '0;

  // result channel
  logic result_valid;
  out_t result;

  // end-of-message register channel
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  // stimulus and scoreboard
  in_t  rx_words[$];
  out_t due_results[$];
  int   send_idle_pct = 0;
  int   err_count     = 0;
  int   stall_cycles  = 0;

  // ring model state
  logic [7:0] ring_mem[DEPTH];
  int         ring_head;
  int         ring_tail;
  int         ring_last;
  logic       ring_full;
  logic       ring_empty;
  logic [7:0] cnt_ovr;
  logic [7:0] cnt_frm;
  logic [7:0] cnt_bovr;
  logic [7:0] cnt_msg;
  logic [7:0] eom_byte;

  uart_receive_ring_buffer #(
    .BUF_DEPTH(DEPTH)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .rx_item     (rx_item),
    .result_valid(result_valid),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

  function automatic int inc_slot(input int i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  // Apply one word to the ring model and return what the block must show.
  function automatic out_t advance_ring(input in_t w);
    out_t r;
    r = '0;
    if (w.mode == MODE_READ) begin
      // flags are don't-care on reads; empty read returns zero, no change
      if (!ring_empty) begin
        r.read_data = ring_mem[RING_IDX_W'(ring_head)];
        ring_head   = inc_slot(ring_head);
        if (ring_head == ring_tail) ring_empty = 1'b1;
        ring_full = 1'b0;
      end
    end else if (w.overrun_error) begin
      // overrun beats framing: drop, count, pulse restart
      r.receiver_restart = 1'b1;
      cnt_ovr            = bump(cnt_ovr);
    end else if (w.framing_error) begin
      cnt_frm = bump(cnt_frm);
    end else begin
      if (ring_full) begin
        // full: clobber the newest entry, indices hold
        cnt_bovr                           = bump(cnt_bovr);
        ring_mem[RING_IDX_W'(ring_last)]   = w.rx_byte;
      end else begin
        ring_last                          = ring_tail;
        ring_mem[RING_IDX_W'(ring_tail)]   = w.rx_byte;
        ring_tail                          = inc_slot(ring_tail);
        if (ring_tail == ring_head) ring_full = 1'b1;
        ring_empty = 1'b0;
      end
      // counted even when the byte overwrote the last entry
      if (w.rx_byte == eom_byte) cnt_msg = bump(cnt_msg);
    end
    r.buffer_empty    = ring_empty;
    r.buffer_full     = ring_full;
    r.overrun_errors  = cnt_ovr;
    r.framing_errors  = cnt_frm;
    r.buffer_overruns = cnt_bovr;
    r.message_count   = cnt_msg;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Driver: hold a word while busy, otherwise maybe idle, otherwise present
  // the next one. start gets one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) due_results.push_back(advance_ring(rx_item));
      if (start && busy) begin
        // not taken yet, keep it on the bus
      end else if (rx_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start   <= 1'b1;
        rx_item <= rx_words.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: a strobed result must be taken in its own cycle.
  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due, read_data", result.read_data, 8'h00);
      end else begin
        want = due_results.pop_front();
        check_field("read_data", result.read_data, want.read_data);
        check_field("buffer_empty", 8'(result.buffer_empty), 8'(want.buffer_empty));
        check_field("buffer_full", 8'(result.buffer_full), 8'(want.buffer_full));
        check_field("overrun_errors", result.overrun_errors, want.overrun_errors);
        check_field("framing_errors", result.framing_errors, want.framing_errors);
        check_field("buffer_overruns", result.buffer_overruns, want.buffer_overruns);
        check_field("message_count", result.message_count, want.message_count);
        check_field("receiver_restart", 8'(result.receiver_restart),
                    8'(want.receiver_restart));
      end
    end
  end

  // Watchdog: any handshake or strobe resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_t make_word(input logic m, input logic [7:0] b,
                                    input logic oe, input logic fe);
    in_t w;
    w.mode          = m;
    w.rx_byte       = b;
    w.overrun_error = oe;
    w.framing_error = fe;
    return w;
  endfunction

  // Random word. Byte values lean toward the message marker and the extremes
  // so message counting and boundary bytes get exercised.
  function automatic in_t rand_word(input int rd_pct, input int ovr_pct,
                                    input int frm_pct);
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 25)      b = eom_byte;
    else if (pick < 33) b = 8'h00;
    else if (pick < 41) b = 8'hFF;
    else                b = 8'($urandom_range(255));
    if ($urandom_range(99) < rd_pct)
      return make_word(MODE_READ, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
    return make_word(MODE_RX, b, $urandom_range(99) < ovr_pct,
                     $urandom_range(99) < frm_pct);
  endfunction

  // Wait until every word is in and every result is out, then let the
  // pipeline go quiet.
  task automatic settle();
    do @(posedge clk);
    while (!(rx_words.size() == 0 && !start && due_results.size() == 0));
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_eom(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    eom_byte = v;
  endtask

  task automatic run_phase(input int idle_pct, input int rd_pct, input int ovr_pct,
                           input int frm_pct, input int n);
    send_idle_pct = idle_pct;
    repeat (n) rx_words.push_back(rand_word(rd_pct, ovr_pct, frm_pct));
    settle();
  endtask

  initial begin
    ring_head  = 0;
    ring_tail  = 0;
    ring_last  = DEPTH - 1;
    ring_full  = 1'b0;
    ring_empty = 1'b1;
    cnt_ovr    = '0;
    cnt_frm    = '0;
    cnt_bovr   = '0;
    cnt_msg    = '0;
    eom_byte   = EOM_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, boundary bytes, marker at reset value,
    // both flags, each flag alone, flags on reads, drain past empty.
    send_idle_pct = 0;
    rx_words.push_back(make_word(MODE_READ, 8'hFF, 1'b1, 1'b1));
    rx_words.push_back(make_word(MODE_RX, 8'h00, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_RX, 8'hFF, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_RX, EOM_RESET, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_RX, 8'hAA, 1'b1, 1'b1));
    rx_words.push_back(make_word(MODE_RX, 8'h55, 1'b0, 1'b1));
    rx_words.push_back(make_word(MODE_RX, EOM_RESET, 1'b1, 1'b0));
    rx_words.push_back(make_word(MODE_RX, 8'h80, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_READ, 8'h00, 1'b1, 1'b0));
    rx_words.push_back(make_word(MODE_READ, 8'h00, 1'b0, 1'b1));
    rx_words.push_back(make_word(MODE_READ, 8'h00, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_READ, 8'h7F, 1'b1, 1'b1));
    rx_words.push_back(make_word(MODE_READ, 8'h00, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_RX, 8'h01, 1'b0, 1'b0));
    rx_words.push_back(make_word(MODE_READ, 8'hFE, 1'b0, 1'b0));
    settle();

    // Random phases. Counters run across phases with no reset between them;
    // write-heavy phases fill the ring and keep it pinned full.
    run_phase(0, 10, 5, 5, 200);
    write_eom(8'h00);
    run_phase(76, 5, 10, 10, 200);
    write_eom(8'hFF);
    run_phase(26, 60, 30, 30, 200);
    write_eom(8'($urandom_range(255)));
    run_phase(0, 8, 50, 10, 250);
    write_eom(EOM_RESET);
    run_phase(50, 50, 10, 10, 135);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
